/* hdl/cpt_pkg.sv */
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_W       = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DOT_W       = 2 * DIFF_W + 2;
  localparam int V_W         = 2 * DOT_W;
  localparam int HALF_W      = V_W / 2;
  localparam int PP_W        = DIFF_W + HALF_W + 1;
  localparam int X_W         = DIFF_W + V_W + 1;
  localparam int REM_W       = X_W + FRAC_BITS + 2;
  localparam int QB          = COORD_W + FRAC_BITS + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic signed [V_W-1:0]     wide_t;
  typedef logic signed [OUT_W-1:0]   out_t;

  typedef enum logic [2:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_EDGE_AB  = 3'd2,
    REG_VERTEX_C = 3'd3,
    REG_EDGE_AC  = 3'd4,
    REG_EDGE_BC  = 3'd5,
    REG_INTERIOR = 3'd6
  } region_t;

  // result = base + (e1*n1 + e2*n2) / den, den > 0
  typedef struct packed {
    coord_t [2:0] base;
    diff_t  [2:0] e1;
    wide_t        n1;
    diff_t  [2:0] e2;
    wide_t        n2;
    wide_t        den;
    region_t      region;
    logic         degenerate;
  } item_t;

endpackage

/* hdl/closest_point_on_triangle_unit.sv */
`timescale 1ns / 1ps

// Closest point on a triangle to a query point, with its Voronoi region code
// and a flag for a zero-area triangle. One item is taken per clock and one
// result leaves per clock while neither side stalls. The front pipeline
// (differences, six dot products, three area products, region decision)
// hands each item to a 4-entry queue; the back pipeline forms the numerators
// and divides them by a 26-stage pipelined restoring divider, one quotient
// bit per stage for each coordinate. Results are in units of 1/256, floored,
// and saturate to 24 bits. Each side stalls on its own: the input keeps
// flowing while a result waits, until the queue fills.
module closest_point_on_triangle_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpt_pkg::coord_t     vertex_a_x,
  input  cpt_pkg::coord_t     vertex_a_y,
  input  cpt_pkg::coord_t     vertex_a_z,
  input  cpt_pkg::coord_t     vertex_b_x,
  input  cpt_pkg::coord_t     vertex_b_y,
  input  cpt_pkg::coord_t     vertex_b_z,
  input  cpt_pkg::coord_t     vertex_c_x,
  input  cpt_pkg::coord_t     vertex_c_y,
  input  cpt_pkg::coord_t     vertex_c_z,
  input  cpt_pkg::coord_t     query_x,
  input  cpt_pkg::coord_t     query_y,
  input  cpt_pkg::coord_t     query_z,
  output logic                out_valid,
  input  logic                out_stall,
  output cpt_pkg::out_t       nearest_x,
  output cpt_pkg::out_t       nearest_y,
  output cpt_pkg::out_t       nearest_z,
  output logic [2:0]          region,
  output logic                degenerate
);

  cpt_pkg::coord_t vert_a [3], vert_b [3], vert_c [3], query [3];
  cpt_pkg::out_t   nearest [3];
  cpt_pkg::item_t  push_item, pop_item;
  logic            push, pop, q_full, q_empty;

  assign vert_a = '{vertex_a_x, vertex_a_y, vertex_a_z};
  assign vert_b = '{vertex_b_x, vertex_b_y, vertex_b_z};
  assign vert_c = '{vertex_c_x, vertex_c_y, vertex_c_z};
  assign query  = '{query_x, query_y, query_z};

  assign nearest_x = nearest[0];
  assign nearest_y = nearest[1];
  assign nearest_z = nearest[2];

  cpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vert_a   (vert_a),
    .vert_b   (vert_b),
    .vert_c   (vert_c),
    .query    (query),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  cpt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  cpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .nearest    (nearest),
    .region     (region),
    .degenerate (degenerate)
  );

endmodule

/* hdl/cpt_front.sv */
`timescale 1ns / 1ps

module cpt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpt_pkg::coord_t  vert_a [3],
  input  cpt_pkg::coord_t  vert_b [3],
  input  cpt_pkg::coord_t  vert_c [3],
  input  cpt_pkg::coord_t  query [3],
  input  logic             q_full,
  output logic             push,
  output cpt_pkg::item_t   item
);

  function automatic cpt_pkg::dot_t dot3(input cpt_pkg::diff_t u [3],
                                         input cpt_pkg::diff_t v [3]);
    logic signed [2*cpt_pkg::DIFF_W-1:0] p [3];
    cpt_pkg::dot_t s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      p[k] = u[k] * v[k];
      s = s + cpt_pkg::dot_t'(p[k]);
    end
    return s;
  endfunction

  logic en;
  logic s1_v, s2_v, s3_v, s4_v;

  cpt_pkg::coord_t s1_a [3], s1_b [3], s1_c [3];
  cpt_pkg::diff_t  s1_ab [3], s1_ac [3], s1_ap [3], s1_bp [3], s1_cp [3], s1_cb [3];

  cpt_pkg::coord_t s2_a [3], s2_b [3], s2_c [3];
  cpt_pkg::diff_t  s2_ab [3], s2_ac [3], s2_cb [3];
  cpt_pkg::dot_t   s2_d [6];

  cpt_pkg::coord_t s3_a [3], s3_b [3], s3_c [3];
  cpt_pkg::diff_t  s3_ab [3], s3_ac [3], s3_cb [3];
  cpt_pkg::dot_t   s3_d [6];
  cpt_pkg::wide_t  s3_pr [6];

  cpt_pkg::wide_t  va, vb, vc, d34, d56, den_in;
  cpt_pkg::wide_t  d1w, d2w, d3w, d6w;
  cpt_pkg::item_t  item_next;

  assign en       = !(s4_v && q_full);
  assign in_stall = !en;
  assign push     = s4_v && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_a[k]  <= vert_a[k];
        s1_b[k]  <= vert_b[k];
        s1_c[k]  <= vert_c[k];
        s1_ab[k] <= cpt_pkg::diff_t'(vert_b[k]) - cpt_pkg::diff_t'(vert_a[k]);
        s1_ac[k] <= cpt_pkg::diff_t'(vert_c[k]) - cpt_pkg::diff_t'(vert_a[k]);
        s1_ap[k] <= cpt_pkg::diff_t'(query[k]) - cpt_pkg::diff_t'(vert_a[k]);
        s1_bp[k] <= cpt_pkg::diff_t'(query[k]) - cpt_pkg::diff_t'(vert_b[k]);
        s1_cp[k] <= cpt_pkg::diff_t'(query[k]) - cpt_pkg::diff_t'(vert_c[k]);
        s1_cb[k] <= cpt_pkg::diff_t'(vert_c[k]) - cpt_pkg::diff_t'(vert_b[k]);
      end
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s2_c  <= s1_c;
      s2_ab <= s1_ab;
      s2_ac <= s1_ac;
      s2_cb <= s1_cb;
      // d1..d6 at index 0..5
      s2_d[0] <= dot3(s1_ab, s1_ap);
      s2_d[1] <= dot3(s1_ac, s1_ap);
      s2_d[2] <= dot3(s1_ab, s1_bp);
      s2_d[3] <= dot3(s1_ac, s1_bp);
      s2_d[4] <= dot3(s1_ab, s1_cp);
      s2_d[5] <= dot3(s1_ac, s1_cp);
      s3_a  <= s2_a;
      s3_b  <= s2_b;
      s3_c  <= s2_c;
      s3_ab <= s2_ab;
      s3_ac <= s2_ac;
      s3_cb <= s2_cb;
      s3_d  <= s2_d;
      s3_pr[0] <= s2_d[0] * s2_d[3];
      s3_pr[1] <= s2_d[2] * s2_d[1];
      s3_pr[2] <= s2_d[4] * s2_d[1];
      s3_pr[3] <= s2_d[0] * s2_d[5];
      s3_pr[4] <= s2_d[2] * s2_d[5];
      s3_pr[5] <= s2_d[4] * s2_d[3];
      item <= item_next;
    end
  end

  always_comb begin
    vc     = s3_pr[0] - s3_pr[1];
    vb     = s3_pr[2] - s3_pr[3];
    va     = s3_pr[4] - s3_pr[5];
    d1w    = cpt_pkg::wide_t'(s3_d[0]);
    d2w    = cpt_pkg::wide_t'(s3_d[1]);
    d3w    = cpt_pkg::wide_t'(s3_d[2]);
    d6w    = cpt_pkg::wide_t'(s3_d[5]);
    d34    = cpt_pkg::wide_t'(s3_d[3]) - d3w;
    d56    = d6w - cpt_pkg::wide_t'(s3_d[4]);
    den_in = va + vb + vc;

    for (int k = 0; k < 3; k++) begin
      item_next.base[k] = s3_a[k];
      item_next.e1[k]   = s3_ab[k];
      item_next.e2[k]   = s3_ac[k];
    end
    item_next.n1         = '0;
    item_next.n2         = '0;
    item_next.den        = cpt_pkg::wide_t'(1);
    item_next.degenerate = 1'b0;
    item_next.region     = cpt_pkg::REG_VERTEX_A;

    if (d1w <= 0 && d2w <= 0) begin
      item_next.region = cpt_pkg::REG_VERTEX_A;
    end else if (d3w >= 0 && d34 <= 0) begin
      item_next.region = cpt_pkg::REG_VERTEX_B;
      for (int k = 0; k < 3; k++) item_next.base[k] = s3_b[k];
    end else if (vc <= 0 && d1w >= 0 && d3w <= 0) begin
      item_next.region = cpt_pkg::REG_EDGE_AB;
      item_next.n1     = d1w;
      item_next.den    = d1w - d3w;
    end else if (d6w >= 0 && d56 >= 0) begin
      item_next.region = cpt_pkg::REG_VERTEX_C;
      for (int k = 0; k < 3; k++) item_next.base[k] = s3_c[k];
    end else if (vb <= 0 && d2w >= 0 && d6w <= 0) begin
      item_next.region = cpt_pkg::REG_EDGE_AC;
      for (int k = 0; k < 3; k++) item_next.e1[k] = s3_ac[k];
      item_next.n1  = d2w;
      item_next.den = d2w - d6w;
    end else if (va <= 0 && d34 >= 0 && d56 <= 0) begin
      item_next.region = cpt_pkg::REG_EDGE_BC;
      for (int k = 0; k < 3; k++) begin
        item_next.base[k] = s3_b[k];
        item_next.e1[k]   = s3_cb[k];
      end
      item_next.n1  = d34;
      item_next.den = d34 - d56;
    end else begin
      item_next.region = cpt_pkg::REG_INTERIOR;
      if (den_in == 0) begin
        item_next.degenerate = 1'b1;
      end else begin
        item_next.n1  = vb;
        item_next.n2  = vc;
        item_next.den = den_in;
      end
    end

    // coincident vertices on an edge: stay at the base vertex
    if (item_next.den == 0) begin
      item_next.n1  = '0;
      item_next.n2  = '0;
      item_next.den = cpt_pkg::wide_t'(1);
    end
  end

endmodule

/* hdl/cpt_fifo.sv */
`timescale 1ns / 1ps

module cpt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output cpt_pkg::item_t pop_item,
  output logic           empty
);

  cpt_pkg::item_t mem [cpt_pkg::QUEUE_DEPTH];
  logic [cpt_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cpt_pkg::PTR_W:0]   count;

  assign full     = count == (cpt_pkg::PTR_W + 1)'(cpt_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{cpt_pkg::PTR_W{1'b0}}, push} - {{cpt_pkg::PTR_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

/* hdl/cpt_back.sv */
`timescale 1ns / 1ps

module cpt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cpt_pkg::item_t  q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output cpt_pkg::out_t   nearest [3],
  output logic [2:0]      region,
  output logic            degenerate
);

  localparam int QB = cpt_pkg::QB;
  localparam int OUT_MAX = 2 ** (cpt_pkg::OUT_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (cpt_pkg::OUT_W - 1));

  typedef logic signed [cpt_pkg::PP_W-1:0]  pp_t;
  typedef logic signed [cpt_pkg::X_W-1:0]   x_t;
  typedef logic        [cpt_pkg::REM_W-1:0] rem_t;
  typedef logic signed [cpt_pkg::REM_W-1:0] srem_t;
  typedef logic signed [QB:0]               off_t;
  typedef logic signed [QB+1:0]             sum_t;

  logic en;

  logic signed [cpt_pkg::HALF_W:0]   n1_lo, n2_lo;
  logic signed [cpt_pkg::HALF_W-1:0] n1_hi, n2_hi;

  logic                 b1_v;
  cpt_pkg::coord_t      b1_base [3];
  cpt_pkg::wide_t       b1_den;
  cpt_pkg::region_t     b1_region;
  logic                 b1_degen;
  pp_t                  b1_p1lo [3], b1_p1hi [3], b1_p2lo [3], b1_p2hi [3];

  logic                 b2_v;
  cpt_pkg::coord_t      b2_base [3];
  cpt_pkg::wide_t       b2_den;
  cpt_pkg::region_t     b2_region;
  logic                 b2_degen;
  x_t                   b2_x [3];

  srem_t                xe [3];
  srem_t                mag [3];
  rem_t                 m3 [3];
  rem_t                 den3;

  logic                 b3_v;
  cpt_pkg::coord_t      b3_base [3];
  rem_t                 b3_den;
  cpt_pkg::region_t     b3_region;
  logic                 b3_degen;
  rem_t                 b3_m [3];
  logic [2:0]           b3_neg;

  // divider pipeline, one quotient bit per stage
  logic                 dv_v [QB+1];
  rem_t                 dv_den [QB+1];
  rem_t                 dv_rem [QB+1][3];
  logic [QB-1:0]        dv_q [QB+1][3];
  cpt_pkg::coord_t      dv_base [QB+1][3];
  logic [2:0]           dv_neg [QB+1];
  logic [2:0]           dv_ovf [QB+1];
  cpt_pkg::region_t     dv_region [QB+1];
  logic                 dv_degen [QB+1];

  rem_t                 st_sh [QB];
  rem_t                 st_rem [QB][3];
  logic [QB-1:0]        st_q [QB][3];

  off_t                 off [3];
  sum_t                 sum [3];
  cpt_pkg::out_t        res [3];

  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_empty;

  assign n1_lo = $signed({1'b0, q_item.n1[cpt_pkg::HALF_W-1:0]});
  assign n1_hi = $signed(q_item.n1[cpt_pkg::V_W-1:cpt_pkg::HALF_W]);
  assign n2_lo = $signed({1'b0, q_item.n2[cpt_pkg::HALF_W-1:0]});
  assign n2_hi = $signed(q_item.n2[cpt_pkg::V_W-1:cpt_pkg::HALF_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j <= QB; j++) dv_v[j] <= 1'b0;
    end else if (en) begin
      b1_v     <= pop;
      b2_v     <= b1_v;
      b3_v     <= b2_v;
      dv_v[0]  <= b3_v;
      for (int j = 0; j < QB; j++) dv_v[j+1] <= dv_v[j];
      out_valid <= dv_v[QB];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xe[k]  = srem_t'(b2_x[k]);
      mag[k] = b2_x[k][cpt_pkg::X_W-1] ? -xe[k] : xe[k];
    end
    den3 = rem_t'($unsigned(b2_den));
    for (int k = 0; k < 3; k++) begin
      // floor of a negative quotient through a rounded-up magnitude
      m3[k] = rem_t'(mag[k] << cpt_pkg::FRAC_BITS) +
              (b2_x[k][cpt_pkg::X_W-1] ? den3 - rem_t'(1) : rem_t'(0));
    end
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      st_sh[j] = dv_den[j] << (QB - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[j][k] >= st_sh[j]) begin
          st_rem[j][k] = dv_rem[j][k] - st_sh[j];
          st_q[j][k]   = {dv_q[j][k][QB-2:0], 1'b1};
        end else begin
          st_rem[j][k] = dv_rem[j][k];
          st_q[j][k]   = {dv_q[j][k][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k] = $signed({1'b0, dv_q[QB][k]});
      if (dv_neg[QB][k]) off[k] = -off[k];
      sum[k] = (sum_t'(dv_base[QB][k]) <<< cpt_pkg::FRAC_BITS) + sum_t'(off[k]);
      if (dv_ovf[QB][k]) begin
        res[k] = dv_neg[QB][k] ? cpt_pkg::out_t'(OUT_MIN) : cpt_pkg::out_t'(OUT_MAX);
      end else if (sum[k] > sum_t'(OUT_MAX)) begin
        res[k] = cpt_pkg::out_t'(OUT_MAX);
      end else if (sum[k] < sum_t'(OUT_MIN)) begin
        res[k] = cpt_pkg::out_t'(OUT_MIN);
      end else begin
        res[k] = sum[k][cpt_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b1_base[k] <= $signed(q_item.base[k]);
        b1_p1lo[k] <= $signed(q_item.e1[k]) * n1_lo;
        b1_p1hi[k] <= $signed(q_item.e1[k]) * n1_hi;
        b1_p2lo[k] <= $signed(q_item.e2[k]) * n2_lo;
        b1_p2hi[k] <= $signed(q_item.e2[k]) * n2_hi;
      end
      b1_den    <= q_item.den;
      b1_region <= q_item.region;
      b1_degen  <= q_item.degenerate;

      for (int k = 0; k < 3; k++) begin
        b2_x[k] <= x_t'(b1_p1lo[k]) + (x_t'(b1_p1hi[k]) <<< cpt_pkg::HALF_W) +
                   x_t'(b1_p2lo[k]) + (x_t'(b1_p2hi[k]) <<< cpt_pkg::HALF_W);
      end
      b2_base   <= b1_base;
      b2_den    <= b1_den;
      b2_region <= b1_region;
      b2_degen  <= b1_degen;

      for (int k = 0; k < 3; k++) begin
        b3_m[k]   <= m3[k];
        b3_neg[k] <= b2_x[k][cpt_pkg::X_W-1];
      end
      b3_base   <= b2_base;
      b3_den    <= den3;
      b3_region <= b2_region;
      b3_degen  <= b2_degen;

      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k]    <= b3_m[k];
        dv_q[0][k]      <= '0;
        dv_ovf[0][k]    <= b3_m[k] >= (b3_den << QB);
      end
      dv_base[0]   <= b3_base;
      dv_den[0]    <= b3_den;
      dv_neg[0]    <= b3_neg;
      dv_region[0] <= b3_region;
      dv_degen[0]  <= b3_degen;

      for (int j = 0; j < QB; j++) begin
        for (int k = 0; k < 3; k++) begin
          dv_rem[j+1][k] <= st_rem[j][k];
          dv_q[j+1][k]   <= st_q[j][k];
        end
        dv_base[j+1]   <= dv_base[j];
        dv_den[j+1]    <= dv_den[j];
        dv_neg[j+1]    <= dv_neg[j];
        dv_ovf[j+1]    <= dv_ovf[j];
        dv_region[j+1] <= dv_region[j];
        dv_degen[j+1]  <= dv_degen[j];
      end

      nearest    <= res;
      region     <= dv_region[QB];
      degenerate <= dv_degen[QB];
    end
  end

endmodule

/* hdl/cpt_checker.sv */
`timescale 1ns / 1ps

module cpt_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input cpt_pkg::out_t   nearest_x,
  input cpt_pkg::out_t   nearest_y,
  input cpt_pkg::out_t   nearest_z,
  input logic [2:0]      region,
  input logic            degenerate
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(nearest_x) && $stable(nearest_y) &&
      $stable(nearest_z) && $stable(region) && $stable(degenerate))
    else $error("stalled result changed");

  a_degen_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> region == cpt_pkg::REG_INTERIOR)
    else $error("degenerate flag outside interior region");

  a_vertex_exact: assert property (@(posedge clk) disable iff (rst)
    out_valid && (region == cpt_pkg::REG_VERTEX_A || region == cpt_pkg::REG_VERTEX_B ||
      region == cpt_pkg::REG_VERTEX_C || degenerate) |->
      nearest_x[cpt_pkg::FRAC_BITS-1:0] == '0 && nearest_y[cpt_pkg::FRAC_BITS-1:0] == '0 &&
      nearest_z[cpt_pkg::FRAC_BITS-1:0] == '0)
    else $error("vertex result has fraction bits");

endmodule

bind closest_point_on_triangle_unit cpt_checker u_checker (.*);
